// ----- rtl/core/sli_pkg.sv -----
// sli_pkg: shared constants and types for the sorted list insert/remove block
// used by sli_ram and sorted_list_insert_remove; no dependencies
package sli_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_CNT_W   = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // access bundle into the entry table
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } sli_ram_req_t;

endpackage

// ----- rtl/core/sli_ram.sv -----
// sli_ram: entry table, one write and one registered read per cycle
// depends on sli_pkg
module sli_ram (
  input  logic                      clk_i,
  input  sli_pkg::sli_ram_req_t     req_i,
  output logic [sli_pkg::VAL_W-1:0] rdata_o
);
  import sli_pkg::*;

  logic [VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sorted_list_insert_remove.sv -----
// sorted_list_insert_remove: ascending table with one entry visited per cycle, uses sli_pkg, sli_ram
// operation: insert walks down from the top entry, moving each larger entry up one slot, then
// writes the value (an empty table takes it at slot 0); remove walks all n entries; refused requests skip the walk
// throughput: one request at a time; the next is taken once the result has registered,
// and a result that is not yet taken holds the block in its capture state
// reset: table empty, no result pending; entry storage is not cleared
module sorted_list_insert_remove (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic signed [sli_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              success_o,
  output logic [sli_pkg::OUT_CNT_W-1:0]     entry_count_o,
  output logic                              is_empty_o,
  output logic signed [sli_pkg::VAL_W-1:0]  smallest_o
);
  import sli_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUT,
    ST_FINISH,
    ST_CAPTURE
  } state_e;

  state_e             state_q, state_d;
  logic               action_q, action_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               issue_q, issue_d;
  logic               dv_q, dv_d;
  logic [IDX_W-1:0]   da_q, da_d;
  logic               found_q, found_d;
  logic               ok_q, ok_d;
  logic               out_valid_q, out_valid_d;
  logic               success_q, success_d;
  logic [OUT_CNT_W-1:0] entry_count_q, entry_count_d;
  logic               is_empty_q, is_empty_d;
  logic [VAL_W-1:0]   smallest_q, smallest_d;

  sli_ram_req_t       ram_req;
  logic [VAL_W-1:0]   rd_data;
  logic [CNT_W+OUT_CNT_W-1:0] count_ext;
  logic               hit;

  sli_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign count_ext  = {{OUT_CNT_W{1'b0}}, count_q};
  assign hit        = (rd_data == value_q);

  always_comb begin
    state_d       = state_q;
    action_d      = action_q;
    value_d       = value_q;
    count_d       = count_q;
    idx_d         = idx_q;
    issue_d       = issue_q;
    dv_d          = 1'b0;
    da_d          = da_q;
    found_d       = found_q;
    ok_d          = ok_q;
    out_valid_d   = out_valid_q;
    success_d     = success_q;
    entry_count_d = entry_count_q;
    is_empty_d    = is_empty_q;
    smallest_d    = smallest_q;
    ram_req       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          value_d  = value_i;
          found_d  = 1'b0;
          ok_d     = 1'b0;
          issue_d  = 1'b0;
          if (action_i == ACT_INSERT) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              state_d = ST_FINISH;
            end else if (count_q == '0) begin
              state_d = ST_PUT;
            end else begin
              idx_d   = IDX_W'(count_q - CNT_W'(1));
              issue_d = 1'b1;
              state_d = ST_WALK;
            end
          end else begin
            if (count_q == '0) begin
              state_d = ST_FINISH;
            end else begin
              idx_d   = '0;
              issue_d = 1'b1;
              state_d = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        // read one entry ahead while the previous one is judged
        ram_req.raddr = idx_q;
        dv_d          = issue_q;
        da_d          = idx_q;
        if (issue_q) begin
          if (action_q == ACT_INSERT) begin
            if (idx_q == '0) begin
              issue_d = 1'b0;
            end else begin
              idx_d = idx_q - IDX_W'(1);
            end
          end else begin
            if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
              issue_d = 1'b0;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
        if (dv_q) begin
          if (action_q == ACT_INSERT) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = da_q + IDX_W'(1);
            if ($signed(rd_data) > value_q) begin
              // larger entry moves up one slot
              ram_req.wdata = rd_data;
              if (da_q == '0) begin
                issue_d = 1'b0;
                dv_d    = 1'b0;
                state_d = ST_PUT;
              end
            end else begin
              ram_req.wdata = value_q;
              ok_d          = 1'b1;
              count_d       = count_q + CNT_W'(1);
              issue_d       = 1'b0;
              dv_d          = 1'b0;
              state_d       = ST_FINISH;
            end
          end else begin
            if (found_q) begin
              // entries past the removed one move down
              ram_req.we    = 1'b1;
              ram_req.waddr = da_q - IDX_W'(1);
              ram_req.wdata = rd_data;
            end else if (hit) begin
              found_d = 1'b1;
            end
            if (CNT_W'(da_q) + CNT_W'(1) == count_q) begin
              dv_d    = 1'b0;
              issue_d = 1'b0;
              ok_d    = found_q | hit;
              if (found_q | hit) begin
                count_d = count_q - CNT_W'(1);
              end
              state_d = ST_FINISH;
            end
          end
        end
      end

      ST_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = value_q;
        ok_d          = 1'b1;
        count_d       = count_q + CNT_W'(1);
        state_d       = ST_FINISH;
      end

      ST_FINISH: begin
        ram_req.raddr = '0;
        state_d       = ST_CAPTURE;
      end

      ST_CAPTURE: begin
        ram_req.raddr = '0;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          success_d     = ok_q;
          entry_count_d = count_ext[OUT_CNT_W-1:0];
          is_empty_d    = (count_q == '0);
          smallest_d    = (count_q == '0) ? '0 : rd_data;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      issue_q       <= 1'b0;
      dv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
      action_q      <= ACT_INSERT;
      value_q       <= '0;
      idx_q         <= '0;
      da_q          <= '0;
      found_q       <= 1'b0;
      ok_q          <= 1'b0;
      success_q     <= 1'b0;
      entry_count_q <= '0;
      is_empty_q    <= 1'b1;
      smallest_q    <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      issue_q       <= issue_d;
      dv_q          <= dv_d;
      out_valid_q   <= out_valid_d;
      action_q      <= action_d;
      value_q       <= value_d;
      idx_q         <= idx_d;
      da_q          <= da_d;
      found_q       <= found_d;
      ok_q          <= ok_d;
      success_q     <= success_d;
      entry_count_q <= entry_count_d;
      is_empty_q    <= is_empty_d;
      smallest_q    <= smallest_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign smallest_o    = smallest_q;

endmodule
